### rtl/pbe_pkg.sv
// ----------------------------------------------------------------------------
// PackBits encoder package
// Shared types, defaults and state codes for the PackBits run-length encoder.
// ----------------------------------------------------------------------------
package pbe_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_RUN_DEF    = 128;
  localparam int WORD_BYTES_DEF = 8;

  // Input item
  typedef struct packed {
    logic       end_of_data;
    logic [7:0] data_byte;
  } pbe_in_t;

  // Result item
  typedef struct packed {
    logic        stream_done;
    logic        last_word;
    logic [3:0]  byte_count;
    logic [63:0] code_word;
  } pbe_out_t;

  // Run bookkeeping held in flops (counts stay below MAX_RUN)
  typedef struct packed {
    logic       in_rep;
    logic [7:0] rep_val;
    logic [7:0] rep_len;
    logic [7:0] lit_len;
  } run_state_t;

  // Outcome of deciding one byte
  typedef struct packed {
    logic       do_rep;
    logic [7:0] rep_flag;
    logic [7:0] rep_byte;
    logic       do_lit;
    logic [7:0] lit_cnt;
    logic       wr_en;
    logic [7:0] wr_idx;
    logic [7:0] wr_byte;
    run_state_t nxt;
  } take_t;

  // One beat from the sequencer into the word packer
  typedef struct packed {
    logic       is_end;
    logic       done;
    logic [7:0] data;
  } pk_beat_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAKE,
    ST_REP_FLAG,
    ST_REP_VAL,
    ST_LIT_FLAG,
    ST_LIT_DATA,
    ST_END
  } pbe_state_e;

endpackage

### rtl/pbe_lit_mem.sv
// ----------------------------------------------------------------------------
// Literal store
// Single-port-write, single-port-read memory with a registered read.
// ----------------------------------------------------------------------------
module pbe_lit_mem #(
  parameter int Depth = pbe_pkg::MAX_RUN_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [7:0]               rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/pbe_take.sv
// ----------------------------------------------------------------------------
// Byte decision unit
// Decides one byte against the open run: extend a repeat, start one, or
// append to the literal run, and says which runs to close.
// ----------------------------------------------------------------------------
module pbe_take #(
  parameter int MAX_RUN = pbe_pkg::MAX_RUN_DEF
) (
  input  pbe_pkg::run_state_t run_i,
  input  logic [7:0]          x0_i,
  input  logic [7:0]          x1_i,
  input  logic [7:0]          x2_i,
  input  logic                have2_i,
  input  logic                final_i,
  output pbe_pkg::take_t      dec_o
);

  localparam logic [7:0] MaxLen = 8'(MAX_RUN);

  logic       rep_match;
  logic       triple;
  logic [7:0] rep_inc;
  logic [7:0] lit_inc;

  assign rep_match = run_i.in_rep && (x0_i == run_i.rep_val);
  assign triple    = have2_i && (x0_i == x1_i) && (x0_i == x2_i);
  assign rep_inc   = run_i.rep_len + 8'd1;
  assign lit_inc   = run_i.lit_len + 8'd1;

  // Flag of a repeat run is 257 - count, i.e. 1 - count mod 256
  always_comb begin
    dec_o          = '0;
    dec_o.nxt      = run_i;
    dec_o.rep_byte = run_i.rep_val;
    dec_o.rep_flag = 8'd1 - run_i.rep_len;
    dec_o.wr_idx   = run_i.lit_len;
    dec_o.wr_byte  = x0_i;
    if (final_i) begin
      // close whatever is open and return to reset values
      dec_o.do_rep  = run_i.in_rep;
      dec_o.do_lit  = (run_i.lit_len != 8'd0);
      dec_o.lit_cnt = run_i.lit_len;
      dec_o.nxt     = '0;
    end else if (rep_match) begin
      if (rep_inc == MaxLen) begin
        dec_o.do_rep      = 1'b1;
        dec_o.rep_flag    = 8'd1 - MaxLen;
        dec_o.nxt.in_rep  = 1'b0;
        dec_o.nxt.rep_len = 8'd0;
      end else begin
        dec_o.nxt.rep_len = rep_inc;
      end
    end else begin
      dec_o.do_rep      = run_i.in_rep;
      dec_o.nxt.in_rep  = 1'b0;
      dec_o.nxt.rep_len = 8'd0;
      if (triple) begin
        dec_o.do_lit      = (run_i.lit_len != 8'd0);
        dec_o.lit_cnt     = run_i.lit_len;
        dec_o.nxt.lit_len = 8'd0;
        dec_o.nxt.in_rep  = 1'b1;
        dec_o.nxt.rep_val = x0_i;
        dec_o.nxt.rep_len = 8'd1;
      end else begin
        dec_o.wr_en = 1'b1;
        if (lit_inc == MaxLen) begin
          dec_o.do_lit      = 1'b1;
          dec_o.lit_cnt     = MaxLen;
          dec_o.nxt.lit_len = 8'd0;
        end else begin
          dec_o.nxt.lit_len = lit_inc;
        end
      end
    end
  end

endmodule

### rtl/pbe_packer.sv
// ----------------------------------------------------------------------------
// Word packer
// Gathers coded bytes low byte first into words and drives the output
// register; an end beat closes the last word of an item.
// ----------------------------------------------------------------------------
module pbe_packer #(
  parameter int WORD_BYTES = pbe_pkg::WORD_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              beat_valid_i,
  output logic              beat_ready_o,
  input  pbe_pkg::pk_beat_t beat_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pbe_pkg::pbe_out_t out_o
);

  localparam int AccW = 8 * WORD_BYTES;
  localparam int CntW = $clog2(WORD_BYTES + 1);

  logic [AccW-1:0]   acc_q, acc_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              o_valid_q, o_valid_d;
  pbe_pkg::pbe_out_t o_data_q, o_data_d;
  logic              slot_free;
  logic              full;
  logic              need_emit;
  logic              fire;
  logic              emit;

  assign slot_free    = !o_valid_q || out_ready_i;
  assign full         = (cnt_q == CntW'(WORD_BYTES));
  assign need_emit    = beat_i.is_end ? (cnt_q != '0) : full;
  assign beat_ready_o = !need_emit || slot_free;
  assign fire         = beat_valid_i && beat_ready_o;
  assign emit         = fire && need_emit;

  // Pack bytes and hand finished words to the output register
  always_comb begin
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    o_data_d  = o_data_q;
    o_valid_d = o_valid_q && !out_ready_i;
    if (emit) begin
      o_valid_d            = 1'b1;
      o_data_d.code_word   = 64'(acc_q);
      o_data_d.byte_count  = 4'(cnt_q);
      o_data_d.last_word   = beat_i.is_end;
      o_data_d.stream_done = beat_i.is_end && beat_i.done;
    end
    if (fire) begin
      if (beat_i.is_end) begin
        cnt_d = '0;
      end else if (full || (cnt_q == '0)) begin
        acc_d = AccW'(beat_i.data);
        cnt_d = CntW'(1);
      end else begin
        acc_d = acc_q | (AccW'(beat_i.data) << {cnt_q, 3'b000});
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      o_valid_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      o_valid_q <= o_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    o_data_q <= o_data_d;
  end

  assign out_valid_o = o_valid_q;
  assign out_o       = o_data_q;

endmodule

### rtl/packbits_run_length_encoder.sv
// ----------------------------------------------------------------------------
// PackBits run-length encoder
// Streams raw bytes in and PackBits code words out, low byte first.
// ----------------------------------------------------------------------------
// A byte that closes no run is taken while the sequencer is idle, so plain
// literal data and long repeats stream at one byte per clock while no run
// closes. A byte that closes a run holds the input while the coded bytes
// leave one per cycle through the word packer, followed by one closing beat:
// a repeat run sends its flag and value, and a literal run of N bytes sends
// its flag and then each stored byte, read one at a time over the single
// read port of the literal store. The final byte of a block is followed by
// one decision per byte in the window (up to three), one closing decision,
// the coded bytes of every run closed and the closing beat before the
// next block is taken. A full word that the receiver holds off stalls these
// steps. Bytes are packed into words of WORD_BYTES; the last word of each
// input byte carries last_word, and the last word of a block also carries
// stream_done. The literal store needs no clearing after reset.
module packbits_run_length_encoder #(
  parameter int MAX_RUN    = pbe_pkg::MAX_RUN_DEF,
  parameter int WORD_BYTES = pbe_pkg::WORD_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pbe_pkg::pbe_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pbe_pkg::pbe_out_t out_o
);

  localparam int AW = $clog2(MAX_RUN);

  pbe_pkg::pbe_state_e state_q, state_d;
  pbe_pkg::run_state_t run_q, run_d;
  logic [7:0]          la0_q, la0_d, la1_q, la1_d;
  logic [1:0]          fill_q, fill_d;
  logic [1:0]          wcnt_q, wcnt_d;
  logic [1:0]          tk_q, tk_d;
  logic                eod_q, eod_d;
  logic [AW-1:0]       idx_q, idx_d;
  logic [7:0]          w0_q, w0_d, w1_q, w1_d, w2_q, w2_d;
  logic [7:0]          rflag_q, rval_q, lit_n_q;
  logic                do_lit_q;

  logic [7:0]          x0, x1, x2;
  logic                have2, fin;
  pbe_pkg::take_t      dec;
  logic                apply;
  logic                accept;
  logic                adv_last;
  logic                beat_valid, beat_ready;
  pbe_pkg::pk_beat_t   beat;
  logic [7:0]          rd_data;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == pbe_pkg::ST_IDLE);
  assign adv_last   = !eod_q || (tk_q == wcnt_q);

  // Select the byte under decision and its two followers
  always_comb begin
    if (state_q == pbe_pkg::ST_IDLE) begin
      x0    = la0_q;
      x1    = la1_q;
      x2    = in_i.data_byte;
      have2 = 1'b1;
      fin   = 1'b0;
    end else begin
      case (tk_q)
        2'd0:    x0 = w0_q;
        2'd1:    x0 = w1_q;
        default: x0 = w2_q;
      endcase
      x1    = (tk_q == 2'd0) ? w1_q : w2_q;
      x2    = w2_q;
      have2 = (tk_q == 2'd0) && (wcnt_q == 2'd3);
      fin   = (tk_q == wcnt_q);
    end
  end

  pbe_take #(
    .MAX_RUN (MAX_RUN)
  ) u_take (
    .run_i   (run_q),
    .x0_i    (x0),
    .x1_i    (x1),
    .x2_i    (x2),
    .have2_i (have2),
    .final_i (fin),
    .dec_o   (dec)
  );

  // Sequence decisions and coded bytes
  always_comb begin
    state_d    = state_q;
    run_d      = run_q;
    la0_d      = la0_q;
    la1_d      = la1_q;
    fill_d     = fill_q;
    wcnt_d     = wcnt_q;
    tk_d       = tk_q;
    eod_d      = eod_q;
    idx_d      = idx_q;
    w0_d       = w0_q;
    w1_d       = w1_q;
    w2_d       = w2_q;
    apply      = 1'b0;
    beat_valid = 1'b0;
    beat       = '0;
    beat.done  = eod_q;
    case (state_q)
      pbe_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_i.end_of_data) begin
            // latch the window and drain it over the next cycles
            case (fill_q)
              2'd0: begin
                w0_d = in_i.data_byte;
              end
              2'd1: begin
                w0_d = la0_q;
                w1_d = in_i.data_byte;
              end
              default: begin
                w0_d = la0_q;
                w1_d = la1_q;
                w2_d = in_i.data_byte;
              end
            endcase
            wcnt_d  = fill_q + 2'd1;
            tk_d    = 2'd0;
            eod_d   = 1'b1;
            fill_d  = 2'd0;
            la0_d   = 8'd0;
            la1_d   = 8'd0;
            state_d = pbe_pkg::ST_TAKE;
          end else if (fill_q == 2'd2) begin
            // decide the oldest byte, shift the lookahead
            apply = 1'b1;
            run_d = dec.nxt;
            la0_d = la1_q;
            la1_d = in_i.data_byte;
            eod_d = 1'b0;
            if (dec.do_rep) begin
              state_d = pbe_pkg::ST_REP_FLAG;
            end else if (dec.do_lit) begin
              state_d = pbe_pkg::ST_LIT_FLAG;
            end
          end else begin
            if (fill_q == 2'd0) begin
              la0_d = in_i.data_byte;
            end else begin
              la1_d = in_i.data_byte;
            end
            fill_d = fill_q + 2'd1;
          end
        end
      end
      pbe_pkg::ST_TAKE: begin
        apply = 1'b1;
        run_d = dec.nxt;
        if (dec.do_rep) begin
          state_d = pbe_pkg::ST_REP_FLAG;
        end else if (dec.do_lit) begin
          state_d = pbe_pkg::ST_LIT_FLAG;
        end else begin
          state_d = adv_last ? pbe_pkg::ST_END : pbe_pkg::ST_TAKE;
          if (!adv_last) begin
            tk_d = tk_q + 2'd1;
          end
        end
      end
      pbe_pkg::ST_REP_FLAG: begin
        beat_valid = 1'b1;
        beat.data  = rflag_q;
        if (beat_ready) begin
          state_d = pbe_pkg::ST_REP_VAL;
        end
      end
      pbe_pkg::ST_REP_VAL: begin
        beat_valid = 1'b1;
        beat.data  = rval_q;
        if (beat_ready) begin
          if (do_lit_q) begin
            state_d = pbe_pkg::ST_LIT_FLAG;
          end else begin
            state_d = adv_last ? pbe_pkg::ST_END : pbe_pkg::ST_TAKE;
            if (!adv_last) begin
              tk_d = tk_q + 2'd1;
            end
          end
        end
      end
      pbe_pkg::ST_LIT_FLAG: begin
        // read of entry 0 is issued here, data arrives next cycle
        beat_valid = 1'b1;
        beat.data  = lit_n_q - 8'd1;
        idx_d      = '0;
        if (beat_ready) begin
          state_d = pbe_pkg::ST_LIT_DATA;
        end
      end
      pbe_pkg::ST_LIT_DATA: begin
        beat_valid = 1'b1;
        beat.data  = rd_data;
        if (beat_ready) begin
          if (8'(idx_q) == lit_n_q - 8'd1) begin
            state_d = adv_last ? pbe_pkg::ST_END : pbe_pkg::ST_TAKE;
            if (!adv_last) begin
              tk_d = tk_q + 2'd1;
            end
          end else begin
            idx_d = idx_q + AW'(1);
          end
        end
      end
      pbe_pkg::ST_END: begin
        // close the last word of this item
        beat_valid  = 1'b1;
        beat.is_end = 1'b1;
        if (beat_ready) begin
          state_d = pbe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pbe_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pbe_pkg::ST_IDLE;
      run_q   <= '0;
      la0_q   <= 8'd0;
      la1_q   <= 8'd0;
      fill_q  <= 2'd0;
      wcnt_q  <= 2'd0;
      tk_q    <= 2'd0;
      eod_q   <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      run_q   <= run_d;
      la0_q   <= la0_d;
      la1_q   <= la1_d;
      fill_q  <= fill_d;
      wcnt_q  <= wcnt_d;
      tk_q    <= tk_d;
      eod_q   <= eod_d;
      idx_q   <= idx_d;
    end
  end

  // Window and run descriptors to emit
  always_ff @(posedge clk_i) begin
    w0_q <= w0_d;
    w1_q <= w1_d;
    w2_q <= w2_d;
    if (apply) begin
      rflag_q  <= dec.rep_flag;
      rval_q   <= dec.rep_byte;
      do_lit_q <= dec.do_lit;
      lit_n_q  <= dec.lit_cnt;
    end
  end

  pbe_lit_mem #(
    .Depth (MAX_RUN)
  ) u_lit_mem (
    .clk_i   (clk_i),
    .we_i    (apply && dec.wr_en),
    .waddr_i (dec.wr_idx[AW-1:0]),
    .wdata_i (dec.wr_byte),
    .raddr_i (idx_d),
    .rdata_o (rd_data)
  );

  pbe_packer #(
    .WORD_BYTES (WORD_BYTES)
  ) u_packer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_valid_i (beat_valid),
    .beat_ready_o (beat_ready),
    .beat_i       (beat),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_o        (out_o)
  );

  // A repeat run never coexists with a pending literal run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q.in_rep |-> (run_q.lit_len == 8'd0))
    else $error("repeat run open with pending literal bytes");

  // Open runs stay below the cap between decisions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_q.lit_len < 8'(MAX_RUN)) && (run_q.rep_len < 8'(MAX_RUN)))
    else $error("run length reached the cap without a flush");

  // Literal read-back stays inside the run being flushed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pbe_pkg::ST_LIT_DATA) |-> (8'(idx_q) < lit_n_q))
    else $error("literal read index past run length");

  // End of block marks the last word of its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.stream_done) |-> out_o.last_word)
    else $error("stream_done without last_word");

endmodule
